FILE: rtl/dedup_packet_fifo_range_count_defines.svh
// Assertion macros shared by the block.
`ifndef DEDUP_PACKET_FIFO_RANGE_COUNT_DEFINES_SVH
`define DEDUP_PACKET_FIFO_RANGE_COUNT_DEFINES_SVH

// Check an implication at each clock edge outside reset.
`define DPF_ASSERT_IMP(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define DPF_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: rtl/dpf_pkg.sv
`timescale 1ns / 1ps
package dpf_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic scan_clr;
    logic scan_step;
    logic commit;
    logic rd_issue;
  } dpf_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
  } dpf_sts_t;

endpackage

FILE: rtl/dpf_ram.sv
`timescale 1ns / 1ps
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one port, registered read on the other.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dpf_datapath.sv
`timescale 1ns / 1ps
module dpf_datapath #(
  parameter int DEPTH      = 64,
  parameter int ADDR_BITS  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dpf_pkg::dpf_ctl_t       ctl,
  output dpf_pkg::dpf_sts_t       sts,
  input  logic [$clog2(DEPTH):0]  limit,
  input  logic [1:0]              in_command,
  input  logic [ADDR_BITS-1:0]    in_src,
  input  logic [ADDR_BITS-1:0]    in_dst,
  input  logic [STAMP_BITS-1:0]   in_stamp,
  input  logic [STAMP_BITS-1:0]   in_lo,
  input  logic [STAMP_BITS-1:0]   in_hi,
  output logic                    res_ok,
  output logic [ADDR_BITS-1:0]    res_src,
  output logic [ADDR_BITS-1:0]    res_dst,
  output logic [STAMP_BITS-1:0]   res_stamp,
  output logic [$clog2(DEPTH):0]  res_count,
  output logic [$clog2(DEPTH):0]  occ
);

  localparam int AW = $clog2(DEPTH);
  localparam int EW = 2 * ADDR_BITS + STAMP_BITS;

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW:0]           occ_r, occ_nxt;
  logic [AW:0]           idx_r, idx_nxt;
  logic                  rv_r;
  logic [AW:0]           cnt_r, cnt_nxt;
  logic                  dup_r, dup_nxt;
  logic [1:0]            cmd_r;
  logic [ADDR_BITS-1:0]  src_r, dst_r;
  logic [STAMP_BITS-1:0] stamp_r, lo_r, hi_r;
  logic [AW-1:0]         raddr, waddr;
  logic [AW:0]           sum;
  logic [EW-1:0]         rdata;
  logic [ADDR_BITS-1:0]  e_src, e_dst;
  logic [STAMP_BITS-1:0] e_stamp;
  logic                  we, evict;

  // Slot of offset within ring.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW:0] off);
    logic [AW+1:0] s;
    s = {2'b0, h} + {1'b0, off};
    if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Read the oldest entry once the scan is through, so a forward finds it in rdata.
  assign raddr = ctl.rd_issue ? head_r : slot(head_r, idx_r);
  assign evict = (occ_r >= limit);
  assign sum   = evict ? occ_r - (AW+1)'(1) : occ_r;
  assign waddr = slot(evict ? slot(head_r, (AW+1)'(1)) : head_r, sum);
  assign we    = ctl.commit && (cmd_r == dpf_pkg::CMD_ADD) && !dup_r;

  dpf_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata({src_r, dst_r, stamp_r}),
    .raddr(raddr), .rdata(rdata)
  );
  assign {e_src, e_dst, e_stamp} = rdata;

  assign sts.scan_last = (idx_r >= occ_r) && !rv_r;
  assign occ = occ_r;

  // Scan index, compare and accumulate.
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    dup_nxt = dup_r;
    if (ctl.scan_clr) begin
      idx_nxt = '0;
      cnt_nxt = '0;
      dup_nxt = 1'b0;
    end else if (ctl.scan_step) begin
      if (idx_r < occ_r) idx_nxt = idx_r + (AW+1)'(1);
      if (rv_r) begin
        if (e_src == src_r && e_dst == dst_r && e_stamp == stamp_r) dup_nxt = 1'b1;
        if (e_dst == dst_r && e_stamp >= lo_r && e_stamp <= hi_r)
          cnt_nxt = cnt_r + (AW+1)'(1);
      end
    end
  end

  // Update ring pointers on commit.
  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    if (ctl.commit) begin
      case (cmd_r)
        dpf_pkg::CMD_ADD: begin
          if (!dup_r) begin
            if (evict) head_nxt = slot(head_r, (AW+1)'(1));
            occ_nxt = sum + (AW+1)'(1);
          end
        end
        dpf_pkg::CMD_FWD: begin
          if (occ_r != '0) begin
            head_nxt = slot(head_r, (AW+1)'(1));
            occ_nxt  = occ_r - (AW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
      rv_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      rv_r   <= ctl.scan_step && (idx_r < occ_r);
    end
  end

  // Hold the request and scan results.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    dup_r <= dup_nxt;
    if (ctl.capture) begin
      cmd_r   <= in_command;
      src_r   <= in_src;
      dst_r   <= in_dst;
      stamp_r <= in_stamp;
      lo_r    <= in_lo;
      hi_r    <= in_hi;
    end
  end

  // Form the result word.
  always_comb begin
    res_ok    = 1'b0;
    res_src   = '0;
    res_dst   = '0;
    res_stamp = '0;
    res_count = '0;
    case (cmd_r)
      dpf_pkg::CMD_ADD: res_ok = !dup_r;
      dpf_pkg::CMD_FWD: begin
        res_ok = (occ_r != '0);
        if (occ_r != '0) begin
          res_src   = e_src;
          res_dst   = e_dst;
          res_stamp = e_stamp;
        end
      end
      dpf_pkg::CMD_COUNT: begin
        res_ok    = 1'b1;
        res_count = cnt_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/dpf_ctrl.sv
`timescale 1ns / 1ps
module dpf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output dpf_pkg::dpf_ctl_t ctl,
  input  dpf_pkg::dpf_sts_t sts,
  output logic              load_out
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  // Sequence scan, commit and output load.
  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    ctl        = '0;
    load_out   = 1'b0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture  = 1'b1;
          ctl.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          ctl.rd_issue = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        ctl.rd_issue = 1'b1;
        if (!ovalid_r || !out_stall) begin
          ctl.commit = 1'b1;
          load_out   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

FILE: rtl/dedup_packet_fifo_range_count.sv
`timescale 1ns / 1ps
// Bounded packet buffer with duplicate filter and range count. Each request runs
// in steps: capture, then for each buffered packet an issue of its read of the
// entry RAM through the single registered read port, a wait for the read latency
// of the last entry, a read of the oldest entry for a forward, and a commit that
// loads the result register; an empty buffer skips the reads and the wait. The commit
// waits while an earlier result is still stalled in that register. A result waits
// in that register while the next request is captured. The limit register applies
// 0 as 1 and any value above DEPTH as DEPTH.
`include "dedup_packet_fifo_range_count_defines.svh"
module dedup_packet_fifo_range_count #(
  parameter int DEPTH      = 64,
  parameter int ADDR_BITS  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic [ADDR_BITS-1:0]   in_src,
  input  logic [ADDR_BITS-1:0]   in_dst,
  input  logic [STAMP_BITS-1:0]  in_stamp,
  input  logic [STAMP_BITS-1:0]  in_range_start,
  input  logic [STAMP_BITS-1:0]  in_range_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic [ADDR_BITS-1:0]   out_src,
  output logic [ADDR_BITS-1:0]   out_dst,
  output logic [STAMP_BITS-1:0]  out_stamp,
  output logic [$clog2(DEPTH):0] out_match_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [6:0]             cfg_memory_limit
);

  localparam int AW = $clog2(DEPTH);

  dpf_pkg::dpf_ctl_t     ctl;
  dpf_pkg::dpf_sts_t     sts;
  logic                  load_out;
  logic [6:0]            lim_r;
  logic [AW:0]           limit, occ;
  logic                  res_ok;
  logic [ADDR_BITS-1:0]  res_src, res_dst;
  logic [STAMP_BITS-1:0] res_stamp;
  logic [AW:0]           res_count;

  assign cfg_ready = 1'b1;

  // Hold the limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) lim_r <= 7'd64;
    else if (cfg_valid) lim_r <= cfg_memory_limit;
  end

  // Clamp the limit to 1..DEPTH.
  always_comb begin
    if (lim_r == 7'd0) limit = (AW+1)'(1);
    else if (32'(lim_r) > DEPTH) limit = (AW+1)'(DEPTH);
    else limit = (AW+1)'(lim_r);
  end

  dpf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .ctl(ctl), .sts(sts),
    .load_out(load_out)
  );

  dpf_datapath #(.DEPTH(DEPTH), .ADDR_BITS(ADDR_BITS), .STAMP_BITS(STAMP_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .limit(limit),
    .in_command(in_command), .in_src(in_src), .in_dst(in_dst), .in_stamp(in_stamp),
    .in_lo(in_range_start), .in_hi(in_range_end), .res_ok(res_ok), .res_src(res_src),
    .res_dst(res_dst), .res_stamp(res_stamp), .res_count(res_count), .occ(occ)
  );

  // Load the output word.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok          <= res_ok;
      out_src         <= res_src;
      out_dst         <= res_dst;
      out_stamp       <= res_stamp;
      out_match_count <= res_count;
    end
  end

  `DPF_ASSERT_IMP(a_occ_bound, clk, rst_n, occ <= (AW+1)'(DEPTH), "occupancy above depth")
  `DPF_ASSERT_NEXT(a_load_valid, clk, rst_n, load_out, out_valid, "result lost")
  `DPF_ASSERT_IMP(a_hold_out, clk, rst_n, !(load_out && out_valid && out_stall), "word lost")

endmodule

FILE: verif/tb_dedup_packet_fifo_range_count.sv
`timescale 1ns / 1ps
module tb_dedup_packet_fifo_range_count;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        ok;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] stamp;
    logic [6:0]  match_count;
  } pkt_result_t;

  // Shadow packet buffer and the queue of results it predicts
  class pkt_buffer_sb;
    logic [15:0] buf_src[DEPTH];
    logic [15:0] buf_dst[DEPTH];
    logic [31:0] buf_stamp[DEPTH];
    int unsigned head;
    int unsigned fill;
    logic [6:0] limit;
    pkt_result_t pending[$];
    int errors;
    int checked;

    function new();
      head = 0;
      fill = 0;
      limit = 7'd64;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned slot(int unsigned ofs);
      return (head + ofs) % DEPTH;
    endfunction

    function int unsigned eff_limit();
      if (limit == 0) return 1;
      if (limit > DEPTH) return DEPTH;
      return limit;
    endfunction

    // Apply one request to the shadow buffer and queue its result
    function void note_request(dpf_pkg::cmd_t cmd, logic [15:0] src, logic [15:0] dst,
                               logic [31:0] stamp, logic [31:0] lo, logic [31:0] hi);
      pkt_result_t r;
      bit dup;
      int unsigned s;
      int unsigned n;
      r = '0;
      dup = 0;
      n = 0;
      case (cmd)
        dpf_pkg::CMD_ADD: begin
          for (int unsigned i = 0; i < fill; i++) begin
            s = slot(i);
            if (buf_src[s] == src && buf_dst[s] == dst && buf_stamp[s] == stamp) dup = 1;
          end
          if (!dup) begin
            if (fill >= eff_limit()) begin
              head = slot(1);
              fill--;
            end
            s = slot(fill);
            buf_src[s] = src;
            buf_dst[s] = dst;
            buf_stamp[s] = stamp;
            fill++;
            r.ok = 1'b1;
          end
        end
        dpf_pkg::CMD_FWD: begin
          if (fill != 0) begin
            r.ok = 1'b1;
            r.src = buf_src[head];
            r.dst = buf_dst[head];
            r.stamp = buf_stamp[head];
            head = slot(1);
            fill--;
          end
        end
        dpf_pkg::CMD_COUNT: begin
          for (int unsigned i = 0; i < fill; i++) begin
            s = slot(i);
            if (buf_dst[s] == dst && buf_stamp[s] >= lo && buf_stamp[s] <= hi) n++;
          end
          r.ok = 1'b1;
          r.match_count = n[6:0];
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    // Compare one result word with the oldest prediction
    task check_result(pkt_result_t got);
      pkt_result_t want;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok) report("ok", got.ok, want.ok);
      if (got.src !== want.src) report("src", got.src, want.src);
      if (got.dst !== want.dst) report("dst", got.dst, want.dst);
      if (got.stamp !== want.stamp) report("stamp", got.stamp, want.stamp);
      if (got.match_count !== want.match_count)
        report("match_count", got.match_count, want.match_count);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [15:0] in_src;
  logic [15:0] in_dst;
  logic [31:0] in_stamp;
  logic [31:0] in_range_start;
  logic [31:0] in_range_end;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [15:0] out_src;
  logic [15:0] out_dst;
  logic [31:0] out_stamp;
  logic [6:0]  out_match_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_memory_limit;

  pkt_buffer_sb sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int idle_cycles;
  int sent;
  int limits_used;

  dedup_packet_fifo_range_count dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_src(in_src), .in_dst(in_dst), .in_stamp(in_stamp),
    .in_range_start(in_range_start), .in_range_end(in_range_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
    .out_src(out_src), .out_dst(out_dst), .out_stamp(out_stamp),
    .out_match_count(out_match_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_memory_limit(cfg_memory_limit)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Drive receiver stall at random, or hold it during a hold-off stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_ok, out_src, out_dst, out_stamp, out_match_count});
  end

  // Count cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired at %0t", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one request, with a random gap first, and hold it until taken.
  // Valid stays up after the handshake until the next gap or a caller drops it.
  task send_word(dpf_pkg::cmd_t cmd, logic [15:0] src, logic [15:0] dst,
                 logic [31:0] stamp, logic [31:0] lo, logic [31:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_src <= src;
    in_dst <= dst;
    in_stamp <= stamp;
    in_range_start <= lo;
    in_range_end <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, src, dst, stamp, lo, hi);
    sent++;
    @(negedge clk);
  endtask

  // Let the block drain, then write the limit register
  task set_limit(logic [6:0] lim);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_memory_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = lim;
    limits_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request, biased toward a small key space so duplicates and hits occur
  task send_random();
    int pick;
    dpf_pkg::cmd_t cmd;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] stamp;
    logic [31:0] lo;
    logic [31:0] hi;
    pick = $urandom_range(99);
    if (pick < 50) cmd = dpf_pkg::CMD_ADD;
    else if (pick < 72) cmd = dpf_pkg::CMD_FWD;
    else if (pick < 96) cmd = dpf_pkg::CMD_COUNT;
    else cmd = dpf_pkg::CMD_NONE;
    if ($urandom_range(3) == 0) begin
      src = $urandom;
      dst = $urandom;
      stamp = $urandom;
      lo = $urandom;
      hi = $urandom;
    end else begin
      src = $urandom_range(3);
      dst = $urandom_range(3);
      stamp = $urandom_range(15);
      lo = $urandom_range(15);
      hi = $urandom_range(15);
    end
    send_word(cmd, src, dst, stamp, lo, hi);
  endtask

  task run_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = dpf_pkg::CMD_ADD;
    in_src = '0;
    in_dst = '0;
    in_stamp = '0;
    in_range_start = '0;
    in_range_end = '0;
    cfg_valid = 1'b0;
    cfg_memory_limit = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    limits_used = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty forward, field extremes, duplicates, ranges, unknown command
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h5A5A, 16'hFFFF, 32'h8000_0000, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);

    // Limit zero acts as one; duplicate of the entry about to be evicted
    set_limit(7'd0);
    send_word(dpf_pkg::CMD_ADD, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h4, 16'h2, 32'h3, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    run_phase(150, 0, 0);

    // Full depth, then lower the limit below occupancy
    set_limit(7'd127);
    for (int i = 0; i < 70; i++)
      send_word(dpf_pkg::CMD_ADD, i[15:0], 16'h7, i, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'h7, 32'h0, 32'h0, 32'hFFFF_FFFF);
    set_limit(7'd3);
    send_word(dpf_pkg::CMD_ADD, 16'h99, 16'h7, 32'h99, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0, 16'h7, 32'h0, 32'h0, 32'hFFFF_FFFF);
    run_phase(200, 75, 0);

    set_limit(7'd8);
    run_phase(200, 0, 75);

    set_limit(7'd64);
    run_phase(200, 28, 28);

    // Long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      run_phase(40, 0, 0);
    join

    set_limit(7'd1);
    run_phase(150, 0, 0);
    set_limit(7'd16);
    run_phase(200, 28, 28);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
    $display("Sent %0d requests, checked %0d results across %0d limit settings",
             sent, sb.checked, limits_used);
    $display("Idle mixes: none, sender 75%%, receiver 75%%, both 28%%, plus a long hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
